[hdl/i14a_pkg.sv]
`timescale 1ns / 1ps
package i14a_pkg;

  localparam int unsigned FrameBytes = 9;
  localparam int unsigned FrameIdxW  = $clog2(FrameBytes);
  localparam int unsigned FrameCntW  = $clog2(FrameBytes + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READY  = 2'd1;
  localparam logic [1:0] ST_ACTIVE = 2'd2;
  localparam logic [1:0] ST_HALT   = 2'd3;

  localparam logic [1:0] KIND_ATQA = 2'd0;
  localparam logic [1:0] KIND_AC   = 2'd1;
  localparam logic [1:0] KIND_SAK  = 2'd2;

  localparam logic [1:0] REG_CASCADE = 2'd0;
  localparam logic [1:0] REG_UID1    = 2'd1;
  localparam logic [1:0] REG_UID2    = 2'd2;
  localparam logic [1:0] REG_UID3    = 2'd3;

  localparam logic [6:0] CMD_REQA   = 7'h26;
  localparam logic [6:0] CMD_WUPA   = 7'h52;
  localparam logic [7:0] CMD_HALT   = 8'h50;
  localparam logic [7:0] CMD_SEL1   = 8'h93;
  localparam logic [7:0] CMD_SEL2   = 8'h95;
  localparam logic [7:0] CMD_SEL3   = 8'h97;
  localparam logic [7:0] NVB_SELECT = 8'h70;
  localparam logic [7:0] SAK_MORE   = 8'h04;
  localparam logic [15:0] CrcPreset = 16'h6363;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
    logic [2:0] final_bits;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [3:0] tx_bits;
    logic [1:0] response_kind;
    logic       response_end;
  } tx_word_t;

  // one finished frame handed from front to back
  typedef struct packed {
    logic [FrameCntW-1:0] count;
    logic [2:0]           final_bits;
  } frame_job_t;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [7:0] ch;
    ch = b ^ crc[7:0];
    ch = ch ^ {ch[3:0], 4'b0};
    return {8'h00, crc[15:8]} ^ {ch, 8'h00} ^ {5'b0, ch, 3'b0} ^ {12'h0, ch[7:4]};
  endfunction

endpackage

[hdl/i14a_ram.sv]
`timescale 1ns / 1ps
module i14a_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/i14a_front.sv]
`timescale 1ns / 1ps
// Collects frame bytes into the store; posts a job on frame end.
module i14a_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  i14a_pkg::rx_word_t         word_i,
  output logic                       we_o,
  output logic [i14a_pkg::FrameIdxW-1:0] waddr_o,
  output logic [7:0]                 wdata_o,
  output logic                       job_valid_o,
  input  logic                       job_ready_i,
  output i14a_pkg::frame_job_t       job_o
);
  import i14a_pkg::*;

  logic [FrameCntW-1:0] count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic                 acc;
  logic                 room;

  // hold off while the store belongs to a frame the back end has not released
  assign ready_o = job_ready_i;
  assign acc     = valid_i && ready_o;
  assign room    = count_q < FrameCntW'(FrameBytes);

  assign we_o    = acc && room;
  assign waddr_o = count_q[FrameIdxW-1:0];
  assign wdata_o = word_i.rx_byte;

  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    job_valid_o = 1'b0;
    job_o.count = room ? count_q + 1'b1 : count_q;
    job_o.final_bits = word_i.final_bits;
    if (acc) begin
      if (room) begin
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      if (word_i.frame_end) begin
        job_valid_o = !ovf_q && room || !ovf_q && !room ? !(ovf_q || !room) : 1'b0;
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FrameCntW'(FrameBytes))
    else $error("frame count past store size");
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_valid_o |-> acc)
    else $error("job without accepted word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && word_i.frame_end |=> count_q == '0 && !ovf_q)
    else $error("frame state not cleared at end");
endmodule

[hdl/i14a_back.sv]
`timescale 1ns / 1ps
// Walks the stored frame one byte per cycle, checks it, then emits the answer.
module i14a_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  output logic                       job_ready_o,
  input  i14a_pkg::frame_job_t       job_i,
  output logic [i14a_pkg::FrameIdxW-1:0] raddr_o,
  input  logic [7:0]                 rdata_i,
  input  logic [1:0]                 cascade_i,
  input  logic [31:0]                uid1_i,
  input  logic [31:0]                uid2_i,
  input  logic [31:0]                uid3_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output i14a_pkg::tx_word_t         word_o
);
  import i14a_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_CRC  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]           st_q, st_d;
  logic [1:0]           card_q, card_d;
  frame_job_t           job_q, job_d;
  logic [FrameCntW-1:0] idx_q, idx_d;      // address issued
  logic [FrameCntW-1:0] didx_q, didx_d;    // index of data on rdata_i
  logic                 dv_q, dv_d;
  logic [7:0]           b_q [FrameBytes];  // captured frame bytes
  logic [7:0]           b_d [FrameBytes];
  logic [15:0]          crc_q, crc_d;
  logic [7:0]           ob_q [5];
  logic [7:0]           ob_d [5];
  logic [3:0]           obits_q, obits_d;   // bits of first out byte
  logic [1:0]           kind_q, kind_d;
  logic [2:0]           on_q, on_d;         // bytes to send
  logic [2:0]           op_q, op_d;         // next byte position
  logic [1:0]           next_card_q, next_card_d;
  tx_word_t             out_q, out_d;
  logic                 ov_q, ov_d;

  logic [6:0]  total;
  logic [31:0] level;
  logic [7:0]  nvb;
  logic [6:0]  nvb_bits;
  logic [5:0]  ubits;
  logic [31:0] rx_uid;
  logic [31:0] umask;
  logic [5:0]  rem;
  logic [2:0]  pb;
  logic [2:0]  m;
  logic [7:0]  bcc;
  logic [7:0]  sak;
  logic [7:0]  pbyte;
  logic [15:0] crc7;
  logic        short7;

  assign job_ready_o = (st_q == S_IDLE);
  assign raddr_o     = idx_q[FrameIdxW-1:0];
  assign valid_o     = ov_q;
  assign word_o      = out_q;

  always_comb begin
    total  = 7'(8 * (job_q.count - 1'b1)) + (job_q.final_bits == 3'd0 ? 7'd8
             : {4'd0, job_q.final_bits});
    short7 = job_q.count == FrameCntW'(1) && total == 7'd7;
    case (b_q[0])
      CMD_SEL1: level = uid1_i;
      CMD_SEL2: level = uid2_i;
      default:  level = uid3_i;
    endcase
    nvb      = b_q[1];
    nvb_bits = {nvb[7:4], 3'b0} + {3'b0, nvb[3:0]};
    ubits    = 6'(total - 7'd16);
    rx_uid   = {b_q[5], b_q[4], b_q[3], b_q[2]};
    umask    = (ubits >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << ubits) - 32'd1);
    rem      = 6'd32 - ubits;
    pb       = rem[2:0];
    m        = rem[5:3];
    bcc      = level[7:0] ^ level[15:8] ^ level[23:16] ^ level[31:24];
    pbyte    = 8'((level >> {ubits[5:3], 3'b0}) & 32'hFF);
    pbyte    = (pbyte >> (4'd8 - {1'b0, pb})) & ((8'd1 << pb) - 8'd1);
    crc7     = crc_q;
    if (b_q[0] == CMD_SEL1) begin
      sak = (cascade_i == 2'd0) ? 8'h00 : SAK_MORE;
    end else if (b_q[0] == CMD_SEL2) begin
      sak = (cascade_i == 2'd1) ? 8'h00 : SAK_MORE;
    end else begin
      sak = 8'h00;
    end
  end

  always_comb begin
    st_d        = st_q;
    card_d      = card_q;
    job_d       = job_q;
    idx_d       = idx_q;
    didx_d      = idx_q;
    dv_d        = 1'b0;
    b_d         = b_q;
    crc_d       = crc_q;
    ob_d        = ob_q;
    obits_d     = obits_q;
    kind_d      = kind_q;
    on_d        = on_q;
    op_d        = op_q;
    next_card_d = next_card_q;
    out_d       = out_q;
    ov_d        = ov_q;
    if (ov_q && ready_i) begin
      ov_d = 1'b0;
    end
    if (dv_q) begin
      b_d[didx_q[FrameIdxW-1:0]] = rdata_i;
    end
    case (st_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_d = job_i;
          idx_d = '0;
          st_d  = S_READ;
        end
      end
      S_READ: begin
        if (idx_q < job_q.count) begin
          dv_d  = 1'b1;
          idx_d = idx_q + 1'b1;
        end else if (!dv_q) begin
          st_d  = S_EVAL;
          crc_d = CrcPreset;
          idx_d = '0;
        end
      end
      S_EVAL: begin
        // crc over the first seven bytes, one per cycle
        if (idx_q < FrameCntW'(7)) begin
          crc_d = crc_step(crc_q, b_q[idx_q[FrameIdxW-1:0]]);
          idx_d = idx_q + 1'b1;
          if (idx_q == FrameCntW'(1)) begin
            crc_d = crc_step(crc_q, b_q[1]);
            ob_d[4] = crc_d[7:0] ^ 8'h00; // keep halt crc
            ob_d[3] = crc_d[15:8];
          end
        end else begin
          st_d = S_IDLE;
          on_d = 3'd0;
          op_d = 3'd0;
          next_card_d = card_q;
          obits_d = 4'd8;
          case (card_q)
            ST_IDLE, ST_HALT: begin
              if (short7 && b_q[0][6:0] == ((card_q == ST_IDLE) ? CMD_REQA : CMD_WUPA)) begin
                ob_d[0] = {cascade_i, 6'h04};
                ob_d[1] = 8'h00;
                on_d = 3'd2;
                kind_d = KIND_ATQA;
                next_card_d = ST_READY;
              end
            end
            ST_ACTIVE: begin
              if (total == 7'd32 && b_q[0] == CMD_HALT && b_q[1] == 8'h00 &&
                  b_q[2] == ob_q[4] && b_q[3] == ob_q[3]) begin
                card_d = ST_HALT;
              end
            end
            default: begin
              if (total >= 7'd16 && (b_q[0] == CMD_SEL1 || b_q[0] == CMD_SEL2 ||
                  b_q[0] == CMD_SEL3)) begin
                if (nvb == NVB_SELECT) begin
                  if (total == 7'd72 && (b_q[2] ^ b_q[3] ^ b_q[4] ^ b_q[5]) == b_q[6] &&
                      b_q[7] == crc7[7:0] && b_q[8] == crc7[15:8] && rx_uid == level) begin
                    ob_d[0] = sak;
                    crc_d = crc_step(CrcPreset, sak);
                    kind_d = KIND_SAK;
                    if (sak == 8'h00) begin
                      next_card_d = ST_ACTIVE;
                    end
                    st_d = S_CRC;
                  end
                end else if ({1'b0, nvb_bits} == total && total <= 7'd48 &&
                             ((rx_uid ^ level) & umask) == 32'd0) begin
                  kind_d = KIND_AC;
                  on_d = 3'd0;
                  if (pb != 3'd0) begin
                    ob_d[0] = pbyte;
                    obits_d = {1'b0, pb};
                    on_d = 3'd1;
                  end
                  for (int i = 0; i < 4; i++) begin
                    if (3'(i) < m) begin
                      ob_d[3'(on_d) + 3'(i)] = level[8*(4-32'(m)+i) +: 8];
                    end
                  end
                  ob_d[on_d + m] = bcc;
                  on_d = on_d + m + 3'd1;
                  st_d = S_OUT;
                end
              end
            end
          endcase
          if (on_d != 3'd0) begin
            st_d = S_OUT;
          end
        end
      end
      S_CRC: begin
        ob_d[1] = crc_q[7:0];
        ob_d[2] = crc_q[15:8];
        on_d = 3'd3;
        op_d = 3'd0;
        obits_d = 4'd8;
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_d) begin
          out_d.tx_byte = ob_q[op_q];
          out_d.tx_bits = (op_q == 3'd0) ? obits_q : 4'd8;
          out_d.response_kind = kind_q;
          out_d.response_end = (op_q + 3'd1 == on_q);
          ov_d = 1'b1;
          op_d = op_q + 3'd1;
          if (op_q + 3'd1 == on_q) begin
            card_d = next_card_q;
            st_d = S_IDLE;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      card_q <= ST_IDLE;
      dv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      card_q <= card_d;
      dv_q   <= dv_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    idx_q       <= idx_d;
    didx_q      <= didx_d;
    b_q         <= b_d;
    crc_q       <= crc_d;
    ob_q        <= ob_d;
    obits_q     <= obits_d;
    kind_q      <= kind_d;
    on_q        <= on_d;
    op_q        <= op_d;
    next_card_q <= next_card_d;
    out_q       <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_o |=> st_q == S_READ)
    else $error("job not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !ready_i |=> ov_q && $stable(out_q))
    else $error("stalled word lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_OUT |-> on_q != 3'd0 && op_q < on_q)
    else $error("output position past response");
endmodule

[hdl/iso14443a_card_activation.sv]
`timescale 1ns / 1ps
// ISO14443A card-side activation.
// Receive channel: one decoded reader byte per word (rx_byte, frame_end,
// final_bits) on valid/ready. Bytes are written to a 9-byte frame store.
// On the last byte the frame is handed to the back end, unless it overran
// the store; the back end reads the store one byte a cycle, runs CRC_A one
// byte a cycle, decides and then sends the answer, one word per response
// byte, on the transmit channel. After a frame end the back end reads the
// store, runs CRC_A and decides, then loads the output register; a SAK
// passes through S_CRC to queue its CRC bytes. While the back end works, rx
// ready is low, so a new frame waits. Each answer word is held in an output
// register; a stalled receiver holds it and the back end waits.
// Reset puts the card in idle, clears the byte count and loads the default
// UID and cascade registers. The APB port writes and reads the registers;
// the user must do so only while the block is idle, as the block itself
// does not enforce it.
module iso14443a_card_activation (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  output logic                rx_ready_o,
  input  i14a_pkg::rx_word_t  rx_word_i,
  output logic                tx_valid_o,
  input  logic                tx_ready_i,
  output i14a_pkg::tx_word_t  tx_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import i14a_pkg::*;

  logic [1:0]  cascade_q;
  logic [31:0] uid1_q, uid2_q, uid3_q;
  logic        we;
  logic [FrameIdxW-1:0] waddr, raddr;
  logic [7:0]  wdata, rdata;
  logic        job_valid, job_ready;
  frame_job_t  job;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cascade_q <= 2'd2;
      uid1_q    <= 32'd2018915346;
      uid2_q    <= 32'd2459013256;
      uid3_q    <= 32'd2728501384;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CASCADE: cascade_q <= pwdata[1:0];
        REG_UID1:    uid1_q    <= pwdata;
        REG_UID2:    uid2_q    <= pwdata;
        REG_UID3:    uid3_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CASCADE: prdata = {30'd0, cascade_q};
      REG_UID1:    prdata = uid1_q;
      REG_UID2:    prdata = uid2_q;
      REG_UID3:    prdata = uid3_q;
      default:     prdata = '0;
    endcase
  end

  i14a_front u_front (
    .clk_i, .rst_ni,
    .valid_i(rx_valid_i), .ready_o(rx_ready_o), .word_i(rx_word_i),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  i14a_ram #(.Width(8), .Depth(FrameBytes)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  i14a_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .raddr_o(raddr), .rdata_i(rdata),
    .cascade_i(cascade_q), .uid1_i(uid1_q), .uid2_i(uid2_q), .uid3_i(uid3_q),
    .valid_o(tx_valid_o), .ready_i(tx_ready_i), .word_o(tx_word_o)
  );
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import i14a_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        rx_valid_i;
  logic        rx_ready_o;
  rx_word_t    rx_word_i;
  logic        tx_valid_o;
  logic        tx_ready_i;
  tx_word_t    tx_word_o;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  iso14443a_card_activation uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .rx_valid_i(rx_valid_i), .rx_ready_o(rx_ready_o), .rx_word_i(rx_word_i),
    .tx_valid_o(tx_valid_o), .tx_ready_i(tx_ready_i), .tx_word_o(tx_word_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rx_word_t    pending_rx[$];
  tx_word_t    expected_tx[$];
  logic [7:0]  frame_buf[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          phases = 0;

  // card model
  logic [1:0]  card_st;
  logic [7:0]  rx_store[FrameBytes];
  int          rx_count;
  bit          rx_over;
  logic [1:0]  cfg_cascade;
  logic [31:0] cfg_uid[3];

  function automatic logic [15:0] crc_a_upd(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  function automatic void push_answer(logic [7:0] b, logic [3:0] bits, logic [1:0] kind,
                                      logic last);
    tx_word_t t;
    t.tx_byte = b;
    t.tx_bits = bits;
    t.response_kind = kind;
    t.response_end = last;
    expected_tx.push_back(t);
  endfunction

  function automatic void answer_atqa();
    push_answer({cfg_cascade, 6'h04}, 4'd8, KIND_ATQA, 1'b0);
    push_answer(8'h00, 4'd8, KIND_ATQA, 1'b1);
    card_st = ST_READY;
  endfunction

  function automatic void answer_anticoll(logic [31:0] uid, int total);
    int ubits, rem, pb, m;
    logic [7:0] b, bcc;
    ubits = total - 16;
    if (ubits > 32) return;
    for (int i = 0; i < ubits; i++)
      if (rx_store[2 + i / 8][i % 8] !== uid[i]) return;
    rem = 32 - ubits;
    pb = rem % 8;
    m = rem / 8;
    if (pb != 0) begin
      b = uid[8 * (ubits / 8) +: 8];
      push_answer((b >> (8 - pb)) & ((8'd1 << pb) - 8'd1), 4'(pb), KIND_AC, 1'b0);
    end
    for (int i = 4 - m; i < 4; i++)
      push_answer(uid[8 * i +: 8], 4'd8, KIND_AC, 1'b0);
    bcc = uid[7:0] ^ uid[15:8] ^ uid[23:16] ^ uid[31:24];
    push_answer(bcc, 4'd8, KIND_AC, 1'b1);
  endfunction

  function automatic void answer_select(logic [7:0] sel, logic [31:0] uid, int total);
    logic [7:0]  bcc, sak;
    logic [15:0] crc;
    if (total != 72) return;
    bcc = rx_store[2] ^ rx_store[3] ^ rx_store[4] ^ rx_store[5];
    if (bcc !== rx_store[6]) return;
    crc = CrcPreset;
    for (int i = 0; i < 7; i++) crc = crc_a_upd(crc, rx_store[i]);
    if (rx_store[7] !== crc[7:0] || rx_store[8] !== crc[15:8]) return;
    for (int i = 0; i < 4; i++)
      if (rx_store[2 + i] !== uid[8 * i +: 8]) return;
    if (sel == CMD_SEL1) sak = (cfg_cascade == 2'd0) ? 8'h00 : SAK_MORE;
    else if (sel == CMD_SEL2) sak = (cfg_cascade == 2'd1) ? 8'h00 : SAK_MORE;
    else sak = 8'h00;
    if (sak == 8'h00) card_st = ST_ACTIVE;
    crc = crc_a_upd(CrcPreset, sak);
    push_answer(sak, 4'd8, KIND_SAK, 1'b0);
    push_answer(crc[7:0], 4'd8, KIND_SAK, 1'b0);
    push_answer(crc[15:8], 4'd8, KIND_SAK, 1'b1);
  endfunction

  function automatic void frame_done(logic [2:0] fb);
    int total, l;
    bit short7;
    logic [7:0] b0, nvb;
    logic [31:0] uid;
    logic [15:0] crc;
    total = 8 * (rx_count - 1) + ((fb == 3'd0) ? 8 : int'(fb));
    short7 = (rx_count == 1) && (total == 7);
    b0 = rx_store[0];
    case (card_st)
      ST_IDLE: if (short7 && b0[6:0] == CMD_REQA) answer_atqa();
      ST_HALT: if (short7 && b0[6:0] == CMD_WUPA) answer_atqa();
      ST_ACTIVE: begin
        if (total == 32 && b0 == CMD_HALT && rx_store[1] == 8'h00) begin
          crc = crc_a_upd(crc_a_upd(CrcPreset, rx_store[0]), rx_store[1]);
          if (rx_store[2] == crc[7:0] && rx_store[3] == crc[15:8]) card_st = ST_HALT;
        end
      end
      default: begin
        if (total < 16) return;
        if (b0 == CMD_SEL1) uid = cfg_uid[0];
        else if (b0 == CMD_SEL2) uid = cfg_uid[1];
        else if (b0 == CMD_SEL3) uid = cfg_uid[2];
        else return;
        nvb = rx_store[1];
        l = int'(nvb[7:4]) * 8 + int'(nvb[3:0]);
        if (nvb == NVB_SELECT) begin
          if (l == total - 16) answer_select(b0, uid, total);
        end else if (l == total) begin
          answer_anticoll(uid, total);
        end
      end
    endcase
  endfunction

  function automatic void card_take(rx_word_t w);
    if (rx_count < FrameBytes) begin
      rx_store[rx_count] = w.rx_byte;
      rx_count++;
    end else begin
      rx_over = 1'b1;
    end
    if (w.frame_end) begin
      if (!rx_over && rx_count > 0) frame_done(w.final_bits);
      rx_count = 0;
      rx_over = 1'b0;
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
      rx_word_i <= '0;
    end else begin
      if (rx_valid_i && rx_ready_o) begin
        card_take(rx_word_i);
        words_in++;
      end
      if (!rx_valid_i || rx_ready_o) begin
        if (pending_rx.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_valid_i <= 1'b1;
          rx_word_i <= pending_rx.pop_front();
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    tx_word_t want;
    if (!rst_ni) begin
      tx_ready_i <= 1'b0;
    end else begin
      if (tx_valid_o && tx_ready_i) begin
        words_out++;
        if (expected_tx.size() == 0) begin
          errors++;
          $display("%0t: unexpected tx word %h", $time, tx_word_o);
        end else begin
          want = expected_tx.pop_front();
          if (tx_word_o.tx_byte !== want.tx_byte || tx_word_o.tx_bits !== want.tx_bits ||
              tx_word_o.response_kind !== want.response_kind ||
              tx_word_o.response_end !== want.response_end) begin
            errors++;
            $display("%0t: tx mismatch exp byte %h bits %0d kind %0d end %0d, got %h %0d %0d %0d",
                     $time, want.tx_byte, want.tx_bits, want.response_kind, want.response_end,
                     tx_word_o.tx_byte, tx_word_o.tx_bits, tx_word_o.response_kind,
                     tx_word_o.response_end);
          end
        end
      end
      tx_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_frame(logic [2:0] fb);
    rx_word_t w;
    while (frame_buf.size() > 0) begin
      w.rx_byte = frame_buf.pop_front();
      w.frame_end = (frame_buf.size() == 0);
      w.final_bits = w.frame_end ? fb : 3'($urandom_range(7));
      pending_rx.push_back(w);
    end
  endtask

  task automatic send_short(logic [6:0] cmd);
    frame_buf.push_back({1'($urandom_range(1)), cmd});
    send_frame(3'd7);
  endtask

  task automatic send_anticoll(int lvl, int ubits, bit corrupt);
    int total, nb;
    logic [63:0] bits;
    total = 16 + ubits;
    nb = (total + 7) / 8;
    bits = {$urandom, cfg_uid[lvl]};
    if (corrupt && ubits > 0) bits[$urandom_range(ubits - 1)] ^= 1'b1;
    frame_buf.push_back(CMD_SEL1 + 8'(2 * lvl));
    frame_buf.push_back({4'(total / 8), 4'(total % 8)});
    for (int i = 0; i < nb - 2; i++) frame_buf.push_back(bits[8 * i +: 8]);
    send_frame(3'(total % 8));
  endtask

  task automatic send_select(int lvl, int corrupt);
    logic [31:0] uid;
    logic [7:0]  bcc;
    logic [15:0] crc;
    uid = cfg_uid[lvl];
    if (corrupt == 1) uid[$urandom_range(31)] ^= 1'b1;
    bcc = uid[7:0] ^ uid[15:8] ^ uid[23:16] ^ uid[31:24];
    if (corrupt == 2) bcc ^= 8'($urandom_range(1, 255));
    frame_buf.push_back(CMD_SEL1 + 8'(2 * lvl));
    frame_buf.push_back(NVB_SELECT);
    for (int i = 0; i < 4; i++) frame_buf.push_back(uid[8 * i +: 8]);
    frame_buf.push_back(bcc);
    crc = CrcPreset;
    foreach (frame_buf[i]) crc = crc_a_upd(crc, frame_buf[i]);
    if (corrupt == 3) crc ^= 16'($urandom_range(1, 65535));
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
    send_frame(3'd0);
  endtask

  task automatic send_halt(bit corrupt);
    logic [15:0] crc;
    crc = crc_a_upd(crc_a_upd(CrcPreset, CMD_HALT), 8'h00);
    if (corrupt) crc ^= 16'h0100;
    frame_buf.push_back(CMD_HALT);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
    send_frame(3'd0);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 11);
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
    send_frame(3'($urandom_range(7)));
  endtask

  // one full activation with random content, now and then broken
  task automatic send_session();
    int levels;
    levels = (cfg_cascade >= 2'd2) ? 3 : int'(cfg_cascade) + 1;
    if ($urandom_range(1)) send_short(CMD_REQA);
    else send_short(CMD_WUPA);
    for (int lvl = 0; lvl < levels; lvl++) begin
      if ($urandom_range(3) != 0)
        send_anticoll(lvl, $urandom_range(9) == 0 ? $urandom_range(33, 40) :
                      $urandom_range(32), $urandom_range(7) == 0);
      send_select(lvl, $urandom_range(5) == 0 ? $urandom_range(1, 3) : 0);
    end
    send_halt($urandom_range(7) == 0);
  endtask

  task automatic drain();
    wait (pending_rx.size() == 0 && !rx_valid_i && expected_tx.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CASCADE: cfg_cascade = val[1:0];
      REG_UID1:    cfg_uid[0] = val;
      REG_UID2:    cfg_uid[1] = val;
      default:     cfg_uid[2] = val;
    endcase
  endtask

  task automatic random_phase(int quota);
    int start;
    phases++;
    start = pending_rx.size();
    while (pending_rx.size() - start < quota)
      if ($urandom_range(4) == 0) send_noise();
      else send_session();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    card_st = ST_IDLE;
    rx_count = 0;
    rx_over = 1'b0;
    cfg_cascade = 2'd2;
    cfg_uid[0] = 32'd2018915346;
    cfg_uid[1] = 32'd2459013256;
    cfg_uid[2] = 32'd2728501384;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset UIDs, triple size
    send_short(CMD_WUPA);          // ignored in idle
    send_short(CMD_REQA);
    send_anticoll(0, 0, 0);        // whole UID back
    send_anticoll(0, 32, 0);       // BCC only
    send_select(0, 0);             // cascade bit set, stays ready
    send_halt(0);                  // not active yet
    random_phase(10);
    drain();

    reg_write(REG_CASCADE, 32'd0);
    reg_write(REG_UID1, $urandom);
    send_idle_pct = 49;
    random_phase(35);
    drain();

    reg_write(REG_CASCADE, 32'd1);
    reg_write(REG_UID2, $urandom);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    random_phase(35);
    drain();

    reg_write(REG_CASCADE, 32'd2);
    reg_write(REG_UID1, 32'hFFFF_FFFF);
    reg_write(REG_UID2, 32'hFFFF_FFFF);
    reg_write(REG_UID3, 32'hFFFF_FFFF);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    random_phase(35);
    drain();

    reg_write(REG_CASCADE, 32'd3);
    reg_write(REG_UID1, 32'h0);
    reg_write(REG_UID2, $urandom);
    reg_write(REG_UID3, 32'h0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(35);
    drain();

    $display("covered %0d rx words over %0d register settings, checked %0d tx words",
             words_in, phases, words_out);
    if (errors == 0) $display("iso14443a_card_activation regression: pass");
    else $display("iso14443a_card_activation regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("iso14443a_card_activation regression: fail");
    $finish;
  end

endmodule
